// ----- sv/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and defaults for the sorted priority queue: actions, result
// status codes, sequencer states and the response flag group.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int unsigned DEPTH_DEF    = 16;
  localparam int unsigned KEY_BITS_DEF = 16;
  localparam int unsigned TAG_BITS_DEF = 16;

  typedef enum logic [2:0] {
    ACT_OFFER   = 3'd0,
    ACT_POLL    = 3'd1,
    ACT_READ    = 3'd2,
    ACT_REM_TAG = 3'd3,
    ACT_REM_AT  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FIN,
    S_HEAD,
    S_HEADW
  } state_e;

  typedef struct packed {
    logic    done;
    logic    busy;
    status_e status;
  } rsp_t;

endpackage

`default_nettype wire

// ----- sv/spq_ram.sv -----
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer for the queue store: walks the RAM one entry per cycle, shifting
// entries up or down or compacting them, then reads the head for the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
  parameter int unsigned DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = spq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = spq_pkg::TAG_BITS_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned DW = KEY_BITS + TAG_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [2:0]          action_i,
  input  wire logic [KEY_BITS-1:0] entry_key_i,
  input  wire logic [TAG_BITS-1:0] entry_tag_i,
  input  wire logic [AW-1:0]       position_index_i,
  input  wire logic                order_descending_i,
  output spq_pkg::rsp_t            rsp_o,
  output logic      [KEY_BITS-1:0] out_key_o,
  output logic      [TAG_BITS-1:0] out_tag_o,
  output logic      [AW-1:0]       placed_position_o,
  output logic      [CW-1:0]       removed_count_o,
  output logic      [CW-1:0]       entry_count_o,
  output logic      [KEY_BITS-1:0] head_key_o,
  output logic      [TAG_BITS-1:0] head_tag_o,
  output logic                     ram_we_o,
  output logic      [AW-1:0]       ram_waddr_o,
  output logic      [DW-1:0]       ram_wdata_o,
  output logic                     ram_re_o,
  output logic      [AW-1:0]       ram_raddr_o,
  input  wire logic [DW-1:0]       ram_rdata_i
);

  spq_pkg::state_e  state_q, state_d;
  spq_pkg::action_e op_q, op_d;
  spq_pkg::status_e status_q, status_d;

  logic [KEY_BITS-1:0] key_q, key_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [AW-1:0]       pos_q, pos_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       left_q, left_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic                rvld_q, rvld_d;
  logic [AW-1:0]       raddr_q, raddr_d;
  logic [CW-1:0]       wptr_q, wptr_d;
  logic [CW-1:0]       removed_q, removed_d;
  logic [AW-1:0]       placed_q, placed_d;
  logic                hit_q, hit_d;
  logic [DW-1:0]       carry_q, carry_d;
  logic [KEY_BITS-1:0] okey_q, okey_d;
  logic [TAG_BITS-1:0] otag_q, otag_d;

  logic                walk_go;
  logic                walk_end;
  logic                outranks;
  logic                rsp_done;
  logic [AW-1:0]       pos_in;
  logic [KEY_BITS-1:0] rkey;
  logic [TAG_BITS-1:0] rtag;

  assign rkey     = ram_rdata_i[DW-1:TAG_BITS];
  assign rtag     = ram_rdata_i[TAG_BITS-1:0];
  assign outranks = order_descending_i ? (key_q > rkey) : (key_q < rkey);
  assign walk_end = !rvld_q && (left_q == '0);
  assign pos_in   = (spq_pkg::action_e'(action_i) == spq_pkg::ACT_POLL) ? '0 : position_index_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      spq_pkg::S_IDLE: begin
        if (start_i) begin
          state_d = walk_go ? spq_pkg::S_WALK : spq_pkg::S_HEAD;
        end
      end
      spq_pkg::S_WALK: begin
        if (walk_end) begin
          state_d = spq_pkg::S_FIN;
        end
      end
      spq_pkg::S_FIN:   state_d = spq_pkg::S_HEAD;
      spq_pkg::S_HEAD:  state_d = spq_pkg::S_HEADW;
      spq_pkg::S_HEADW: state_d = spq_pkg::S_IDLE;
      default:          state_d = spq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    op_d        = op_q;
    status_d    = status_q;
    key_d       = key_q;
    tag_d       = tag_q;
    pos_d       = pos_q;
    cnt_d       = cnt_q;
    left_d      = left_q;
    ptr_d       = ptr_q;
    wptr_d      = wptr_q;
    removed_d   = removed_q;
    placed_d    = placed_q;
    hit_d       = hit_q;
    carry_d     = carry_q;
    okey_d      = okey_q;
    otag_d      = otag_q;
    walk_go     = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = placed_q;
    ram_wdata_o = {key_q, tag_q};
    ram_re_o    = 1'b0;
    ram_raddr_o = ptr_q;
    rsp_done    = 1'b0;

    case (state_q)
      spq_pkg::S_IDLE: begin
        if (start_i) begin
          op_d      = spq_pkg::action_e'(action_i);
          key_d     = entry_key_i;
          tag_d     = entry_tag_i;
          pos_d     = pos_in;
          status_d  = spq_pkg::ST_OK;
          okey_d    = '0;
          otag_d    = '0;
          placed_d  = '0;
          removed_d = '0;
          wptr_d    = '0;
          hit_d     = 1'b0;
          case (spq_pkg::action_e'(action_i))
            spq_pkg::ACT_OFFER: begin
              if (cnt_q == CW'(DEPTH)) begin
                status_d = spq_pkg::ST_FULL;
              end else if (cnt_q == '0) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = '0;
                ram_wdata_o = {entry_key_i, entry_tag_i};
                cnt_d       = cnt_q + CW'(1);
              end else begin
                walk_go  = 1'b1;
                ptr_d    = '0;
                left_d   = cnt_q;
                placed_d = AW'(cnt_q);
              end
            end
            spq_pkg::ACT_POLL, spq_pkg::ACT_REM_AT, spq_pkg::ACT_READ: begin
              if (CW'(pos_in) >= cnt_q) begin
                status_d = spq_pkg::ST_MISS;
              end else begin
                walk_go = 1'b1;
                ptr_d   = pos_in;
                left_d  = (spq_pkg::action_e'(action_i) == spq_pkg::ACT_READ) ?
                          CW'(1) : cnt_q - CW'(pos_in);
              end
            end
            spq_pkg::ACT_REM_TAG: begin
              if (cnt_q == '0) begin
                status_d = spq_pkg::ST_MISS;
              end else begin
                walk_go = 1'b1;
                ptr_d   = '0;
                left_d  = cnt_q;
              end
            end
            default: status_d = spq_pkg::ST_MISS;
          endcase
        end
      end

      spq_pkg::S_WALK: begin
        if (left_q != '0) begin
          ram_re_o = 1'b1;
          left_d   = left_q - CW'(1);
          ptr_d    = ptr_q + AW'(1);
        end
        if (rvld_q) begin
          case (op_q)
            spq_pkg::ACT_OFFER: begin
              if (hit_q) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = raddr_q;
                ram_wdata_o = carry_q;
                carry_d     = ram_rdata_i;
              end else if (outranks) begin
                ram_we_o    = 1'b1;
                ram_waddr_o = raddr_q;
                ram_wdata_o = {key_q, tag_q};
                carry_d     = ram_rdata_i;
                hit_d       = 1'b1;
                placed_d    = raddr_q;
              end
            end
            spq_pkg::ACT_POLL, spq_pkg::ACT_REM_AT: begin
              if (raddr_q == pos_q) begin
                okey_d = rkey;
                otag_d = rtag;
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = raddr_q - AW'(1);
                ram_wdata_o = ram_rdata_i;
              end
            end
            spq_pkg::ACT_READ: begin
              okey_d = rkey;
              otag_d = rtag;
            end
            spq_pkg::ACT_REM_TAG: begin
              if (rtag == tag_q) begin
                removed_d = removed_q + CW'(1);
              end else begin
                ram_we_o    = 1'b1;
                ram_waddr_o = wptr_q[AW-1:0];
                ram_wdata_o = ram_rdata_i;
                wptr_d      = wptr_q + CW'(1);
              end
            end
            default: ;
          endcase
        end
      end

      spq_pkg::S_FIN: begin
        case (op_q)
          spq_pkg::ACT_OFFER: begin
            ram_we_o    = 1'b1;
            ram_waddr_o = AW'(cnt_q);
            ram_wdata_o = hit_q ? carry_q : {key_q, tag_q};
            cnt_d       = cnt_q + CW'(1);
          end
          spq_pkg::ACT_POLL, spq_pkg::ACT_REM_AT: begin
            cnt_d = cnt_q - CW'(1);
          end
          spq_pkg::ACT_REM_TAG: begin
            cnt_d = wptr_q;
            if (removed_q == '0) begin
              status_d = spq_pkg::ST_MISS;
            end
          end
          default: ;
        endcase
      end

      spq_pkg::S_HEAD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = '0;
      end

      spq_pkg::S_HEADW: begin
        rsp_done = 1'b1;
      end

      default: ;
    endcase
  end

  assign rvld_d  = ram_re_o;
  assign raddr_d = ram_raddr_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spq_pkg::S_IDLE;
      cnt_q   <= '0;
      left_q  <= '0;
      rvld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      rvld_q  <= rvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    status_q  <= status_d;
    key_q     <= key_d;
    tag_q     <= tag_d;
    pos_q     <= pos_d;
    ptr_q     <= ptr_d;
    raddr_q   <= raddr_d;
    wptr_q    <= wptr_d;
    removed_q <= removed_d;
    placed_q  <= placed_d;
    hit_q     <= hit_d;
    carry_q   <= carry_d;
    okey_q    <= okey_d;
    otag_q    <= otag_d;
  end

  assign rsp_o.done        = rsp_done;
  assign rsp_o.busy        = (state_q != spq_pkg::S_IDLE);
  assign rsp_o.status      = status_q;
  assign out_key_o         = okey_q;
  assign out_tag_o         = otag_q;
  assign placed_position_o = placed_q;
  assign removed_count_o   = removed_q;
  assign entry_count_o     = cnt_q;
  assign head_key_o        = (cnt_q != '0) ? rkey : '0;
  assign head_tag_o        = (cnt_q != '0) ? rtag : '0;

endmodule

`default_nettype wire

// ----- sv/sorted_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Priority queue of up to DEPTH key/tag entries held in service order in one
// RAM: offer, poll, read at, remove by tag and remove at, with head and count
// reported on every result.
//
//   channel   signals                                      transfer
//   command   start, busy, action_i, entry_key_i,          start & !busy
//             entry_tag_i, position_index_i
//   result    done_o, status_o, out_key_o, out_tag_o,      done_o (one cycle)
//             placed_position_o, removed_count_o,
//             entry_count_o, head_key_o, head_tag_o
//   config    cfg_valid_i, cfg_ready_o, cfg_data_i         valid & ready
//
// A command that fails its check, or an offer into an empty queue, skips
// the walk; otherwise the sequencer walks the single RAM read port one entry
// per cycle. Every command then reads the head entry.
// The result shows in an output register, so the next command is taken in
// the cycle that result is presented. The receiver cannot stall.
// Reset empties the queue at once; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH    = spq_pkg::DEPTH_DEF,
  parameter int unsigned KEY_BITS = spq_pkg::KEY_BITS_DEF,
  parameter int unsigned TAG_BITS = spq_pkg::TAG_BITS_DEF,
  localparam int unsigned AW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1),
  localparam int unsigned DW = KEY_BITS + TAG_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [2:0]          action_i,
  input  wire logic [KEY_BITS-1:0] entry_key_i,
  input  wire logic [TAG_BITS-1:0] entry_tag_i,
  input  wire logic [AW-1:0]       position_index_i,
  output logic                     done_o,
  output logic      [1:0]          status_o,
  output logic      [KEY_BITS-1:0] out_key_o,
  output logic      [TAG_BITS-1:0] out_tag_o,
  output logic      [AW-1:0]       placed_position_o,
  output logic      [CW-1:0]       removed_count_o,
  output logic      [CW-1:0]       entry_count_o,
  output logic      [KEY_BITS-1:0] head_key_o,
  output logic      [TAG_BITS-1:0] head_tag_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic                cfg_data_i
);

  spq_pkg::rsp_t rsp;

  logic                order_q;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DW-1:0]       ram_wdata;
  logic                ram_re;
  logic [AW-1:0]       ram_raddr;
  logic [DW-1:0]       ram_rdata;

  logic [KEY_BITS-1:0] c_out_key;
  logic [TAG_BITS-1:0] c_out_tag;
  logic [AW-1:0]       c_placed;
  logic [CW-1:0]       c_removed;
  logic [CW-1:0]       c_count;
  logic [KEY_BITS-1:0] c_head_key;
  logic [TAG_BITS-1:0] c_head_tag;

  logic                done_q;
  spq_pkg::status_e    status_q;
  logic [KEY_BITS-1:0] out_key_q;
  logic [TAG_BITS-1:0] out_tag_q;
  logic [AW-1:0]       placed_q;
  logic [CW-1:0]       removed_q;
  logic [CW-1:0]       count_q;
  logic [KEY_BITS-1:0] head_key_q;
  logic [TAG_BITS-1:0] head_tag_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        order_q <= cfg_data_i;
      end
      done_q <= rsp.done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.done) begin
      status_q   <= rsp.status;
      out_key_q  <= c_out_key;
      out_tag_q  <= c_out_tag;
      placed_q   <= c_placed;
      removed_q  <= c_removed;
      count_q    <= c_count;
      head_key_q <= c_head_key;
      head_tag_q <= c_head_tag;
    end
  end

  spq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spq_ctrl #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS)
  ) u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .action_i           (action_i),
    .entry_key_i        (entry_key_i),
    .entry_tag_i        (entry_tag_i),
    .position_index_i   (position_index_i),
    .order_descending_i (order_q),
    .rsp_o              (rsp),
    .out_key_o          (c_out_key),
    .out_tag_o          (c_out_tag),
    .placed_position_o  (c_placed),
    .removed_count_o    (c_removed),
    .entry_count_o      (c_count),
    .head_key_o         (c_head_key),
    .head_tag_o         (c_head_tag),
    .ram_we_o           (ram_we),
    .ram_waddr_o        (ram_waddr),
    .ram_wdata_o        (ram_wdata),
    .ram_re_o           (ram_re),
    .ram_raddr_o        (ram_raddr),
    .ram_rdata_i        (ram_rdata)
  );

  assign busy              = rsp.busy;
  assign done_o            = done_q;
  assign status_o          = status_q;
  assign out_key_o         = out_key_q;
  assign out_tag_o         = out_tag_q;
  assign placed_position_o = placed_q;
  assign removed_count_o   = removed_q;
  assign entry_count_o     = count_q;
  assign head_key_o        = head_key_q;
  assign head_tag_o        = head_tag_q;

endmodule

`default_nettype wire
